// File: hdl/md5_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round tables for the MD5 hash engine.
// Depends on nothing; the other files that use it refer to it by scoped names.
package md5_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned CountW = 61;

  localparam logic [WordW-1:0] IvA = 32'h67452301;
  localparam logic [WordW-1:0] IvB = 32'hefcdab89;
  localparam logic [WordW-1:0] IvC = 32'h98badcfe;
  localparam logic [WordW-1:0] IvD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;

  // Control from the sequencer to the compression unit.
  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctl_t;

  // What the sequencer does once a compression has finished.
  typedef enum logic [1:0] {
    AFT_IDLE = 2'd0,
    AFT_PAD  = 2'd1,
    AFT_ZERO = 2'd2,
    AFT_OUT  = 2'd3
  } after_e;

  function automatic logic [WordW-1:0] round_const(input logic [5:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Message word used by round r.
  function automatic logic [AddrW-1:0] msg_idx(input logic [5:0] r);
    logic [AddrW-1:0] i;
    logic [AddrW-1:0] lo;
    lo = r[3:0];
    case (r[5:4])
      2'd0: i = lo;
      2'd1: i = AddrW'((lo << 2) + lo + 4'd1);
      2'd2: i = AddrW'((lo << 1) + lo + 4'd5);
      default: i = AddrW'((lo << 3) - lo);
    endcase
    return i;
  endfunction

endpackage

// File: hdl/md5_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for message bytes and digest results.
// Depends on nothing.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;
  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;
  modport source (output valid, digest_a, digest_b, digest_c, digest_d, input ready);
  modport sink (input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

// File: hdl/md5_block_ram.sv
`timescale 1ns / 1ps
// Sixteen-word message block memory, one write and one registered read port.
// Depends on md5_pkg.
module md5_block_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [md5_pkg::AddrW-1:0] waddr_i,
  input  logic [md5_pkg::WordW-1:0] wdata_i,
  input  logic [md5_pkg::AddrW-1:0] raddr_i,
  output logic [md5_pkg::WordW-1:0] rdata_o
);

  logic [md5_pkg::WordW-1:0] mem [16];
  logic [md5_pkg::WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/md5_compress.sv
`timescale 1ns / 1ps
// MD5 compression unit: one round per cycle over the block memory, then the
// chaining update. Depends on md5_pkg.
module md5_compress (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  md5_pkg::cmp_ctl_t         ctl_i,
  input  logic [md5_pkg::WordW-1:0] rdata_i,
  output logic [md5_pkg::AddrW-1:0] raddr_o,
  output logic                      busy_o,
  output logic [md5_pkg::WordW-1:0] chain_a_o,
  output logic [md5_pkg::WordW-1:0] chain_b_o,
  output logic [md5_pkg::WordW-1:0] chain_c_o,
  output logic [md5_pkg::WordW-1:0] chain_d_o
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_PRE  = 4'b0010,
    C_RUN  = 4'b0100,
    C_ADD  = 4'b1000
  } cstate_e;

  cstate_e st_q, st_d;
  logic [5:0] r_q, r_d;
  logic [md5_pkg::WordW-1:0] ha_q, hb_q, hc_q, hd_q;
  logic [md5_pkg::WordW-1:0] wa_q, wb_q, wc_q, wd_q;
  logic [md5_pkg::WordW-1:0] f, t, rot;
  logic [2*md5_pkg::WordW-1:0] dbl;

  always_comb begin
    case (r_q[5:4])
      2'd0: f = (wb_q & wc_q) | (~wb_q & wd_q);
      2'd1: f = (wd_q & wb_q) | (~wd_q & wc_q);
      2'd2: f = wb_q ^ wc_q ^ wd_q;
      default: f = wc_q ^ (wb_q | ~wd_q);
    endcase
    t   = f + wa_q + md5_pkg::round_const(r_q) + rdata_i;
    dbl = {t, t} << md5_pkg::rot_amt(r_q);
    rot = dbl[2*md5_pkg::WordW-1:md5_pkg::WordW];
  end

  always_comb begin
    st_d    = st_q;
    r_d     = r_q;
    raddr_o = md5_pkg::msg_idx(r_q);
    case (st_q)
      C_IDLE: begin
        raddr_o = md5_pkg::msg_idx(6'd0);
        if (ctl_i.start) begin
          st_d = C_PRE;
        end
      end
      C_PRE: begin
        raddr_o = md5_pkg::msg_idx(6'd0);
        r_d     = 6'd0;
        st_d    = C_RUN;
      end
      C_RUN: begin
        raddr_o = md5_pkg::msg_idx(6'(r_q + 6'd1));
        r_d     = 6'(r_q + 6'd1);
        if (r_q == 6'd63) begin
          st_d = C_ADD;
        end
      end
      C_ADD: st_d = C_IDLE;
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE;
      r_q  <= '0;
      ha_q <= md5_pkg::IvA;
      hb_q <= md5_pkg::IvB;
      hc_q <= md5_pkg::IvC;
      hd_q <= md5_pkg::IvD;
    end else begin
      st_q <= st_d;
      r_q  <= r_d;
      if (ctl_i.init) begin
        ha_q <= md5_pkg::IvA;
        hb_q <= md5_pkg::IvB;
        hc_q <= md5_pkg::IvC;
        hd_q <= md5_pkg::IvD;
      end else if (st_q == C_ADD) begin
        ha_q <= ha_q + wa_q;
        hb_q <= hb_q + wb_q;
        hc_q <= hc_q + wc_q;
        hd_q <= hd_q + wd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == C_PRE) begin
      wa_q <= ha_q;
      wb_q <= hb_q;
      wc_q <= hc_q;
      wd_q <= hd_q;
    end else if (st_q == C_RUN) begin
      wa_q <= wd_q;
      wd_q <= wc_q;
      wc_q <= wb_q;
      wb_q <= wb_q + rot;
    end
  end

  assign busy_o    = (st_q != C_IDLE);
  assign chain_a_o = ha_q;
  assign chain_b_o = hb_q;
  assign chain_c_o = hc_q;
  assign chain_d_o = hd_q;

endmodule

// File: hdl/md5_hash_engine.sv
`timescale 1ns / 1ps
// MD5 hash engine top level: byte packing, padding sequencer and output register.
// Depends on md5_pkg, md5_if, md5_block_ram and md5_compress.
//
// Message bytes arrive one per transfer on in_i and are packed little-endian
// into a sixteen-word block memory. Every 64th byte starts a compression
// that reads the block memory one word per cycle and runs one MD5 round per
// cycle, during which no byte is taken. A transfer with last_byte set
// appends the 0x80 marker, zero fill and the 64-bit bit length, written one
// word per cycle, and runs one final compression, or two when fewer than
// nine bytes of the block remain. The digest appears as one transfer on
// out_o. It sits in an output register, so the next message may start
// while the digest waits; only the end of that next message waits for the
// register to drain. After the digest the chaining words and the byte count
// return to their initial values.
module md5_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  md5_in_if.sink      in_i,
  md5_out_if.source   out_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAD    = 6'b000010,
    S_ZERO   = 6'b000100,
    S_LEN    = 6'b001000,
    S_CSTART = 6'b010000,
    S_CWAIT  = 6'b100000
  } state_e;

  state_e st_q, st_d;
  md5_pkg::after_e after_q, after_d;
  logic [md5_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [md5_pkg::WordW-1:0]  asm_q, asm_d;
  logic [4:0]                 zp_q, zp_d;
  logic                       two_q, two_d;
  logic                       lenhi_q, lenhi_d;
  logic                       ovalid_q, ovalid_d;
  logic                       oload;
  logic [md5_pkg::WordW-1:0]  da_q, db_q, dc_q, dd_q;

  logic                       we;
  logic [md5_pkg::AddrW-1:0]  waddr, raddr;
  logic [md5_pkg::WordW-1:0]  wdata, rdata, padw;
  logic [4:0]                 zlim;
  logic                       busy;
  logic [md5_pkg::WordW-1:0]  ca, cb, cc, cd;
  md5_pkg::cmp_ctl_t          ctl;
  logic                       accept;

  md5_block_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  md5_compress u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rdata_i   (rdata),
    .raddr_o   (raddr),
    .busy_o    (busy),
    .chain_a_o (ca),
    .chain_b_o (cb),
    .chain_c_o (cc),
    .chain_d_o (cd)
  );

  assign in_i.ready = (st_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Padding word: bytes already packed stay, the marker goes in the next
  // lane and the lanes above it are cleared.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (j < int'(cnt_q[1:0])) begin
        padw[8*j +: 8] = asm_q[8*j +: 8];
      end else if (j == int'(cnt_q[1:0])) begin
        padw[8*j +: 8] = md5_pkg::PadByte;
      end else begin
        padw[8*j +: 8] = 8'h00;
      end
    end
  end

  assign zlim = two_q ? 5'd16 : 5'd14;

  always_comb begin
    st_d     = st_q;
    after_d  = after_q;
    cnt_d    = cnt_q;
    asm_d    = asm_q;
    zp_d     = zp_q;
    two_d    = two_q;
    lenhi_d  = lenhi_q;
    we       = 1'b0;
    waddr    = cnt_q[5:2];
    wdata    = '0;
    ctl      = '0;
    oload    = 1'b0;
    ovalid_d = ovalid_q;
    if (out_o.valid && out_o.ready) begin
      ovalid_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.byte_present) begin
            asm_d[8*cnt_q[1:0] +: 8] = in_i.data_byte;
            if (cnt_q[1:0] == 2'd3) begin
              we    = 1'b1;
              wdata = {in_i.data_byte, asm_q[23:0]};
            end
            cnt_d = cnt_q + 1'b1;
            if (cnt_q[5:0] == 6'd63) begin
              after_d = in_i.last_byte ? md5_pkg::AFT_PAD : md5_pkg::AFT_IDLE;
              st_d    = S_CSTART;
            end else if (in_i.last_byte) begin
              st_d = S_PAD;
            end
          end else if (in_i.last_byte) begin
            st_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        we    = 1'b1;
        waddr = cnt_q[5:2];
        wdata = padw;
        zp_d  = 5'({1'b0, cnt_q[5:2]} + 5'd1);
        two_d = (cnt_q[5:3] == 3'b111);
        st_d  = S_ZERO;
      end
      S_ZERO: begin
        if (zp_q == zlim) begin
          if (two_q) begin
            after_d = md5_pkg::AFT_ZERO;
            st_d    = S_CSTART;
          end else begin
            lenhi_d = 1'b0;
            st_d    = S_LEN;
          end
        end else begin
          we    = 1'b1;
          waddr = zp_q[3:0];
          wdata = '0;
          zp_d  = 5'(zp_q + 5'd1);
        end
      end
      S_LEN: begin
        we = 1'b1;
        if (lenhi_q) begin
          waddr   = 4'd15;
          wdata   = cnt_q[60:29];
          after_d = md5_pkg::AFT_OUT;
          st_d    = S_CSTART;
        end else begin
          waddr   = 4'd14;
          wdata   = {cnt_q[28:0], 3'b000};
          lenhi_d = 1'b1;
        end
      end
      S_CSTART: begin
        ctl.start = 1'b1;
        st_d      = S_CWAIT;
      end
      S_CWAIT: begin
        if (!busy) begin
          case (after_q)
            md5_pkg::AFT_IDLE: st_d = S_IDLE;
            md5_pkg::AFT_PAD:  st_d = S_PAD;
            md5_pkg::AFT_ZERO: begin
              zp_d  = '0;
              two_d = 1'b0;
              st_d  = S_ZERO;
            end
            md5_pkg::AFT_OUT: begin
              if (!ovalid_q || out_o.ready) begin
                oload    = 1'b1;
                ovalid_d = 1'b1;
                ctl.init = 1'b1;
                cnt_d    = '0;
                st_d     = S_IDLE;
              end
            end
            default: st_d = S_IDLE;
          endcase
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      after_q  <= md5_pkg::AFT_IDLE;
      cnt_q    <= '0;
      zp_q     <= '0;
      two_q    <= 1'b0;
      lenhi_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      after_q  <= after_d;
      cnt_q    <= cnt_d;
      zp_q     <= zp_d;
      two_q    <= two_d;
      lenhi_q  <= lenhi_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
    if (oload) begin
      da_q <= ca;
      db_q <= cb;
      dc_q <= cc;
      dd_q <= cd;
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.digest_a = da_q;
  assign out_o.digest_b = db_q;
  assign out_o.digest_c = dc_q;
  assign out_o.digest_d = dd_q;

endmodule

// File: test/md5_hash_checker.sv
`timescale 1ns / 1ps
// Digest predictor and scoreboard for the MD5 hash engine testbench.
// Depends on md5_pkg and md5_if; watches both channels without driving them.
module md5_hash_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  md5_in_if          in_mon,
  md5_out_if         out_mon,
  output int         fail_cnt_o,
  output int         pending_o
);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int ShiftTab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                   6, 10, 15, 21};

  logic [31:0]                chain [4];
  logic [31:0]                blk [16];
  logic [md5_pkg::CountW-1:0] nbytes;
  digest_t                    digest_q[$];
  int                         fails;

  assign fail_cnt_o = fails;
  assign pending_o  = digest_q.size();

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One 64-round compression of the block into the chaining words.
  task automatic fold_block();
    logic [31:0] a, b, c, d, f, t;
    int w;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin f = (b & c) | (~b & d); w = r; end
        1: begin f = (d & b) | (~d & c); w = (5 * r + 1) % 16; end
        2: begin f = b ^ c ^ d; w = (3 * r + 5) % 16; end
        default: begin f = c ^ (b | ~d); w = (7 * r) % 16; end
      endcase
      t = f + a + RoundK[r] + blk[w];
      a = d; d = c; c = b;
      b = b + rotl(t, ShiftTab[(r / 16) * 4 + r % 4]);
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic pack_byte(int pos, logic [7:0] v);
    if (pos % 4 == 0) blk[pos / 4] = '0;
    blk[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  task automatic restart();
    chain[0] = md5_pkg::IvA; chain[1] = md5_pkg::IvB;
    chain[2] = md5_pkg::IvC; chain[3] = md5_pkg::IvD;
    nbytes = '0;
  endtask

  task automatic absorb(logic [7:0] data, logic present, logic last);
    int pos;
    logic [63:0] bits;
    if (present) begin
      pack_byte(int'(nbytes[5:0]), data);
      nbytes = nbytes + 1'b1;
      if (nbytes[5:0] == 0) fold_block();
    end
    if (last) begin
      pos = int'(nbytes[5:0]);
      pack_byte(pos, md5_pkg::PadByte);
      for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
      if (pos >= 56) begin
        fold_block();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      bits = {nbytes, 3'b000};
      blk[14] = bits[31:0];
      blk[15] = bits[63:32];
      fold_block();
      digest_q.push_back('{chain[0], chain[1], chain[2], chain[3]});
      restart();
    end
  endtask

  initial begin
    fails = 0;
    restart();
    for (int i = 0; i < 16; i++) blk[i] = '0;
  end

  always @(posedge clk_i) begin
    digest_t exp_d;
    digest_t got;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.digest_a, out_mon.digest_b, out_mon.digest_c, out_mon.digest_d};
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest %h", $time, got);
          fails++;
        end else begin
          exp_d = digest_q.pop_front();
          if (got.a !== exp_d.a) begin
            $display("%0t: digest_a expected %h actual %h", $time, exp_d.a, got.a);
            fails++;
          end
          if (got.b !== exp_d.b) begin
            $display("%0t: digest_b expected %h actual %h", $time, exp_d.b, got.b);
            fails++;
          end
          if (got.c !== exp_d.c) begin
            $display("%0t: digest_c expected %h actual %h", $time, exp_d.c, got.c);
            fails++;
          end
          if (got.d !== exp_d.d) begin
            $display("%0t: digest_d expected %h actual %h", $time, exp_d.d, got.d);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb(in_mon.data_byte, in_mon.byte_present, in_mon.last_byte);
    end
  end

endmodule

// File: test/tb_md5_hash_engine.sv
`timescale 1ns / 1ps
// Top of the MD5 hash engine testbench: clock, reset, byte stimulus and verdict.
// Depends on md5_if, md5_hash_engine and md5_hash_checker.
module tb_md5_hash_engine;

  // No transfer on either side for this many cycles means the engine hung.
  // The slowest legal gap is a final double compression plus
  // the long receiver hold-off below.
  localparam int StallLimit = 20000;
  localparam int HoldOff    = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int   idle_cycles;
  bit   gaps_on;
  bit   hold_out;
  int   sent;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_hash_engine DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  md5_hash_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;
    gaps_on   = 1'b1;
    hold_out  = 1'b0;
  end

  // Sends one transfer, idling first at random when gaps are enabled.
  task automatic send_byte(logic [7:0] data, logic present, logic last);
    while (gaps_on && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data;
    in_ch.byte_present <= present;
    in_ch.last_byte    <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // A whole message of random bytes; its length decides where the padding falls.
  task automatic send_message(int len, bit end_marker);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), 1'b1, !end_marker && i == len - 1);
    if (end_marker || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random back-pressure, with quiet and hold-off stretches.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_out) out_ch.ready <= 1'b0;
      else out_ch.ready <= !(gaps_on && $urandom_range(99) < 21);
    end
  end

  // Watchdog on transfers of either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int len;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty message, byte extremes, idle no-byte items,
    // and lengths at the padding boundaries.
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h5a, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hff, 1'b1, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(64, 1'b1);
    send_message(63, 1'b0);

    // Back-pressure: the receiver holds off while several short messages go in,
    // so the output register fills and the engine stops taking bytes.
    hold_out = 1'b1;
    fork
      begin
        repeat (HoldOff) @(posedge clk_i);
        hold_out = 1'b0;
      end
      begin
        send_message(3, 1'b0);
        send_message(5, 1'b1);
        send_message(2, 1'b0);
      end
    join

    // A quiet stretch without any idling on either side.
    gaps_on = 1'b0;
    send_message(70, 1'b0);
    send_message(10, 1'b1);
    gaps_on = 1'b1;

    // Random messages, mostly short, a few crossing block boundaries,
    // with the occasional stray no-byte item.
    while (sent < 650) begin
      case ($urandom_range(9))
        0: len = $urandom_range(130, 56);
        1: send_byte(8'($urandom), 1'b0, 1'b0);
        default: len = $urandom_range(20, 0);
      endcase
      send_message(len, $urandom_range(1));
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
